@@ sv/sbp_pkg.sv @@
package sbp_pkg;

  // Fixed sizes of the panel
  localparam int NUM_DIGITS = 4;
  localparam int DIG_W      = 4;
  localparam int CUR_W      = 2;
  localparam int CNT_W      = 10;
  localparam int DUTY_W     = 14;
  localparam int BTN_W      = 4;
  localparam int SEG_W      = 8;

  // Button bit positions
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;

  // Register reset values
  localparam logic [CNT_W-1:0] PWM_PERIOD_RST  = 10'd1000;
  localparam logic [CNT_W-1:0] BLINK_PERIOD_RST = 10'd1000;
  localparam logic [CNT_W-1:0] BLANK_FROM_RST  = 10'd500;

  // Largest BCD digit
  localparam logic [DIG_W-1:0] DIG_MAX = 4'd9;

  // Register indexes on the config port
  typedef enum logic [1:0] {
    REG_PWM_PERIOD   = 2'd0,
    REG_BLINK_PERIOD = 2'd1,
    REG_BLANK_FROM   = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  // Configuration as seen by the core
  typedef struct packed {
    logic [CNT_W-1:0] pwm_period;
    logic [CNT_W-1:0] blink_period;
    logic [CNT_W-1:0] blank_from;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic [BTN_W-1:0]  anodes;
    logic              pwm_level;
    logic              pulse_request;
    logic [DUTY_W-1:0] duty_value;
    logic [CUR_W-1:0]  cursor_position;
  } result_t;

  // Active-low seven-segment code, bit7 is the decimal point (off)
  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIG_W-1:0] dig);
    logic [SEG_W-1:0] seg;
    case (dig)
      4'd0:    seg = 8'b1100_0000;
      4'd1:    seg = 8'b1111_1001;
      4'd2:    seg = 8'b1010_0100;
      4'd3:    seg = 8'b1011_0000;
      4'd4:    seg = 8'b1001_1001;
      4'd5:    seg = 8'b1001_0010;
      4'd6:    seg = 8'b1000_0010;
      4'd7:    seg = 8'b1111_1000;
      4'd8:    seg = 8'b1000_0000;
      4'd9:    seg = 8'b1001_1000;
      default: seg = 8'b1111_1111;
    endcase
    return seg;
  endfunction

  // Free-running counter step: wraps to zero at or above the period
  function automatic logic [CNT_W-1:0] cnt_advance(input logic [CNT_W-1:0] cnt,
                                                    input logic [CNT_W-1:0] period);
    logic [CNT_W:0] n;
    n = {1'b0, cnt} + {{CNT_W{1'b0}}, 1'b1};
    if (n >= {1'b0, period}) begin
      n = '0;
    end
    return n[CNT_W-1:0];
  endfunction

endpackage

@@ sv/sbp_regs.sv @@
module sbp_regs
  import sbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period   <= PWM_PERIOD_RST;
      cfg_r.blink_period <= BLINK_PERIOD_RST;
      cfg_r.blank_from   <= BLANK_FROM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_PWM_PERIOD:   cfg_r.pwm_period   <= pwdata[CNT_W-1:0];
        REG_BLINK_PERIOD: cfg_r.blink_period <= pwdata[CNT_W-1:0];
        REG_BLANK_FROM:   cfg_r.blank_from   <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_PWM_PERIOD:   prdata = {{(32-CNT_W){1'b0}}, cfg_r.pwm_period};
      REG_BLINK_PERIOD: prdata = {{(32-CNT_W){1'b0}}, cfg_r.blink_period};
      REG_BLANK_FROM:   prdata = {{(32-CNT_W){1'b0}}, cfg_r.blank_from};
      default:          prdata = '0;
    endcase
  end

endmodule

@@ sv/sbp_core.sv @@
module sbp_core
  import sbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [BTN_W-1:0] buttons,
  input  logic             edit_mode,
  input  cfg_t             cfg,
  output result_t          res
);

  // Panel state
  logic [DIG_W-1:0]  dig_r [NUM_DIGITS];
  logic [DIG_W-1:0]  dig_nxt [NUM_DIGITS];
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [CUR_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  blink_r, blink_nxt;
  logic [CNT_W-1:0]  pwm_cnt_r, pwm_cnt_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic [BTN_W-1:0]  hist_r, hist_nxt;

  logic [BTN_W-1:0]  rise;
  logic [DIG_W-1:0]  cur_dig, dig_up, dig_dn;
  logic [SEG_W-1:0]  seg;
  logic [BTN_W-1:0]  an;
  logic              pulse;

  always_comb begin
    rise = buttons & ~hist_r;

    // Display scan from start-of-tick state
    seg = seg_decode(dig_r[scan_r]);
    if (scan_r == CUR_W'(1)) begin
      seg[SEG_W-1] = ~seg[SEG_W-1];
    end
    blink_nxt = cnt_advance(blink_r, cfg.blink_period);
    if (blink_nxt >= cfg.blank_from && scan_r == cursor_r) begin
      an = '1;
    end else begin
      an = ~(BTN_W'(1) << scan_r);
    end
    scan_nxt = scan_r + CUR_W'(1);

    // PWM compare, then count
    pwm_cnt_nxt = cnt_advance(pwm_cnt_r, cfg.pwm_period);

    // Button handling
    cursor_nxt = cursor_r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    duty_nxt = duty_r;
    pulse    = 1'b0;
    cur_dig  = '0;
    dig_up   = '0;
    dig_dn   = '0;
    if (edit_mode) begin
      if (rise[BTN_LEFT]) begin
        cursor_nxt = cursor_nxt + CUR_W'(1);
      end
      if (rise[BTN_RIGHT]) begin
        cursor_nxt = cursor_nxt + CUR_W'(3);
      end
      cur_dig = dig_r[cursor_nxt];
      dig_up  = (rise[BTN_UP] && cur_dig < DIG_MAX) ? cur_dig + DIG_W'(1) : cur_dig;
      dig_dn  = (rise[BTN_DOWN] && dig_up != '0) ? dig_up - DIG_W'(1) : dig_up;
      dig_nxt[cursor_nxt] = dig_dn;
      // Duty is the four digits read as a decimal number
      duty_nxt = DUTY_W'(dig_nxt[0]) * DUTY_W'(1000)
               + DUTY_W'(dig_nxt[1]) * DUTY_W'(100)
               + DUTY_W'(dig_nxt[2]) * DUTY_W'(10)
               + DUTY_W'(dig_nxt[3]);
      hist_nxt = buttons;
    end else begin
      pulse    = rise[BTN_DOWN];
      hist_nxt = hist_r;
      hist_nxt[BTN_DOWN] = buttons[BTN_DOWN];
    end

    res.segments        = seg;
    res.anodes          = an;
    res.pwm_level       = ({{(DUTY_W-CNT_W){1'b0}}, pwm_cnt_r} < duty_r);
    res.pulse_request   = pulse;
    res.duty_value      = duty_nxt;
    res.cursor_position = cursor_nxt;
  end

  // State update once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_r[i] <= '0;
      end
      cursor_r  <= '0;
      scan_r    <= '0;
      blink_r   <= '0;
      pwm_cnt_r <= '0;
      duty_r    <= '0;
      hist_r    <= '0;
    end else if (step) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        dig_r[i] <= dig_nxt[i];
      end
      cursor_r  <= cursor_nxt;
      scan_r    <= scan_nxt;
      blink_r   <= blink_nxt;
      pwm_cnt_r <= pwm_cnt_nxt;
      duty_r    <= duty_nxt;
      hist_r    <= hist_nxt;
    end
  end

endmodule

@@ sv/bcd_setpoint_panel_pwm_top.sv @@
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+-------------------
// input    | in_buttons, in_edit_mode                      | in_valid / in_ready
// result   | out_segments .. out_cursor_position           | out_valid/out_ready
// config   | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready tied high
//
// One request per cycle sustained while the result is not stalled; a request
// passes the input register, then the result register. The tick logic between
// them updates the panel state. Reset (rst_n low, synchronous) clears the
// pipeline, panel state and loads the register defaults. A stalled result holds
// the pipeline; the input register still takes a request while it is empty or
// the result register is free or drains.
module bcd_setpoint_panel_pwm_top
  import sbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BTN_W-1:0]  in_buttons,
  input  logic              in_edit_mode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SEG_W-1:0]  out_segments,
  output logic [BTN_W-1:0]  out_anodes,
  output logic              out_pwm_level,
  output logic              out_pulse_request,
  output logic [DUTY_W-1:0] out_duty_value,
  output logic [CUR_W-1:0]  out_cursor_position,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t             cfg;
  result_t          res, res_r;
  logic             in_vld_r, out_vld_r;
  logic [BTN_W-1:0] btn_r;
  logic             edit_r;
  logic             adv, step;

  // Pipeline moves when the result register is free or being taken
  assign adv      = ~out_vld_r | out_ready;
  assign step     = in_vld_r & adv;
  assign in_ready = ~in_vld_r | adv;

  sbp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .buttons   (btn_r),
    .edit_mode (edit_r),
    .cfg       (cfg),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      btn_r  <= in_buttons;
      edit_r <= in_edit_mode;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_segments        = res_r.segments;
  assign out_anodes          = res_r.anodes;
  assign out_pwm_level       = res_r.pwm_level;
  assign out_pulse_request   = res_r.pulse_request;
  assign out_duty_value      = res_r.duty_value;
  assign out_cursor_position = res_r.cursor_position;

endmodule

@@ sim/panel_checker.sv @@
`timescale 1ns / 1ps

module panel_checker
  import sbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BTN_W-1:0]  in_buttons,
  input  logic              in_edit_mode,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [SEG_W-1:0]  out_segments,
  input  logic [BTN_W-1:0]  out_anodes,
  input  logic              out_pwm_level,
  input  logic              out_pulse_request,
  input  logic [DUTY_W-1:0] out_duty_value,
  input  logic [CUR_W-1:0]  out_cursor_position,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  // Active-low patterns for 0..9, all segments off above nine
  localparam logic [SEG_W-1:0] SEG_CODE [16] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
    8'h80, 8'h98, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
  };

  // Shadow of the registers and the panel state
  cfg_t              cfg_q;
  logic [DIG_W-1:0]  digits [NUM_DIGITS];
  logic [CUR_W-1:0]  cursor;
  logic [1:0]        scan_idx;
  logic [CNT_W-1:0]  blink_cnt;
  logic [CNT_W-1:0]  pwm_cnt;
  logic [DUTY_W-1:0] duty;
  logic [BTN_W-1:0]  btn_hist;
  result_t           panel_out_q [$];
  int                mismatches = 0;

  assign fail_count = mismatches;

  // Free-running count: clears once it reaches its period
  function automatic logic [CNT_W-1:0] next_count(input logic [CNT_W-1:0] cnt,
                                                  input logic [CNT_W-1:0] period);
    int unsigned n;
    n = int'(cnt) + 1;
    return (n >= int'(period)) ? '0 : CNT_W'(n);
  endfunction

  // One loop tick of the panel: display, PWM, then buttons
  task automatic run_panel_tick(input logic [BTN_W-1:0] btn, input logic edit,
                                output result_t res);
    logic [BTN_W-1:0] rise;
    logic [CUR_W-1:0] c;
    int               sum;
    rise = btn & ~btn_hist;
    res = '0;

    // display scan uses the digits and cursor from the start of the tick
    res.segments = SEG_CODE[digits[scan_idx]];
    if (scan_idx == 2'd1) res.segments[SEG_W-1] = ~res.segments[SEG_W-1];
    blink_cnt = next_count(blink_cnt, cfg_q.blink_period);
    if (blink_cnt >= cfg_q.blank_from && scan_idx == cursor)
      res.anodes = '1;
    else
      res.anodes = ~(BTN_W'(1) << scan_idx);
    scan_idx = scan_idx + 2'd1;

    // PWM compare before the count moves
    res.pwm_level = (pwm_cnt < duty);
    pwm_cnt = next_count(pwm_cnt, cfg_q.pwm_period);

    if (edit) begin
      if (rise[BTN_LEFT]) cursor = cursor + 1'b1;
      if (rise[BTN_RIGHT]) cursor = cursor - 1'b1;
      c = cursor;
      if (rise[BTN_UP] && digits[c] < DIG_MAX) digits[c] = digits[c] + 1'b1;
      if (rise[BTN_DOWN] && digits[c] > 0) digits[c] = digits[c] - 1'b1;
      sum = digits[0] * 1000 + digits[1] * 100 + digits[2] * 10 + digits[3];
      duty = DUTY_W'(sum);
      btn_hist = btn;
    end else begin
      // only the down history follows the buttons outside edit mode
      res.pulse_request = rise[BTN_DOWN];
      btn_hist[BTN_DOWN] = btn[BTN_DOWN];
    end
    res.duty_value = duty;
    res.cursor_position = cursor;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t          want;
    logic [CNT_W-1:0] rd_want;
    if (!rst_n) begin
      cfg_q = {PWM_PERIOD_RST, BLINK_PERIOD_RST, BLANK_FROM_RST};
      for (int i = 0; i < NUM_DIGITS; i++) digits[i] = '0;
      cursor = '0;
      scan_idx = '0;
      blink_cnt = '0;
      pwm_cnt = '0;
      duty = '0;
      btn_hist = '0;
      panel_out_q.delete();
      pending <= 0;
    end else begin
      // register port: track writes, check read data
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[3:2]))
            REG_PWM_PERIOD:   cfg_q.pwm_period = pwdata[CNT_W-1:0];
            REG_BLINK_PERIOD: cfg_q.blink_period = pwdata[CNT_W-1:0];
            REG_BLANK_FROM:   cfg_q.blank_from = pwdata[CNT_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_t'(paddr[3:2]))
            REG_PWM_PERIOD:   rd_want = cfg_q.pwm_period;
            REG_BLINK_PERIOD: rd_want = cfg_q.blink_period;
            REG_BLANK_FROM:   rd_want = cfg_q.blank_from;
            default:          rd_want = '0;
          endcase
          check_field("register read", {22'd0, rd_want}, prdata);
        end
      end

      // result side: compare against the oldest prediction
      if (out_valid && out_ready) begin
        if (panel_out_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending, expected nothing, got seg 0x%0h",
                   $time, out_segments);
        end else begin
          want = panel_out_q.pop_front();
          check_field("segments", 32'(want.segments), 32'(out_segments));
          check_field("anodes", 32'(want.anodes), 32'(out_anodes));
          check_field("pwm_level", 32'(want.pwm_level), 32'(out_pwm_level));
          check_field("pulse_request", 32'(want.pulse_request), 32'(out_pulse_request));
          check_field("duty_value", 32'(want.duty_value), 32'(out_duty_value));
          check_field("cursor_position", 32'(want.cursor_position),
                      32'(out_cursor_position));
        end
      end

      // request side: predict the tick
      if (in_valid && in_ready) begin
        run_panel_tick(in_buttons, in_edit_mode, want);
        panel_out_q.push_back(want);
      end
      pending <= panel_out_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sbp_pkg::*;

  localparam int TOTAL_TICKS  = 1750;
  localparam int PHASE_TICKS  = 220;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [BTN_W-1:0] B_UP    = BTN_W'(1) << BTN_UP;
  localparam logic [BTN_W-1:0] B_DOWN  = BTN_W'(1) << BTN_DOWN;
  localparam logic [BTN_W-1:0] B_LEFT  = BTN_W'(1) << BTN_LEFT;
  localparam logic [BTN_W-1:0] B_RIGHT = BTN_W'(1) << BTN_RIGHT;
  localparam logic [BTN_W-1:0] B_ALL   = '1;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_HOLD} ready_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BTN_W-1:0]  in_buttons = '0;
  logic              in_edit_mode = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [SEG_W-1:0]  out_segments;
  logic [BTN_W-1:0]  out_anodes;
  logic              out_pwm_level;
  logic              out_pulse_request;
  logic [DUTY_W-1:0] out_duty_value;
  logic [CUR_W-1:0]  out_cursor_position;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  int                ticks_sent = 0;
  int                burst_left = 1;
  int                cycle_count = 0;
  ready_mode_t       ready_mode = RDY_ALWAYS;
  int                ready_left = 0;

  bcd_setpoint_panel_pwm_top dut (.*);
  panel_checker panel_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side back-pressure, with a pattern picked anew at random intervals
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(4, 40);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
      default:    out_ready <= 1'b0;
    endcase
  end

  // One tick request; bursts end in a random idle gap
  task automatic send_tick(input logic [BTN_W-1:0] btn, input logic edit);
    int gap;
    in_valid <= 1'b1;
    in_buttons <= btn;
    in_edit_mode <= edit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  // Stop requests and wait until every result is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    drain();
    apb_access(1'b1, REG_PWM_PERIOD, {22'd0, c.pwm_period});
    apb_access(1'b1, REG_BLINK_PERIOD, {22'd0, c.blink_period});
    apb_access(1'b1, REG_BLANK_FROM, {22'd0, c.blank_from});
    apb_access(1'b0, REG_PWM_PERIOD, '0);
    apb_access(1'b0, REG_BLINK_PERIOD, '0);
    apb_access(1'b0, REG_BLANK_FROM, '0);
  endtask

  function automatic logic [CNT_W-1:0] pick_period();
    case ($urandom_range(0, 3))
      0:       return CNT_W'(1);
      1:       return CNT_W'(1023);
      2:       return CNT_W'($urandom_range(2, 16));
      default: return CNT_W'($urandom_range(1, 1023));
    endcase
  endfunction

  // Hand-picked ticks with the reset configuration
  task automatic run_directed();
    send_tick('0, 1'b0);
    send_tick(B_DOWN, 1'b0);                    // pulse request
    send_tick(B_DOWN, 1'b0);                    // held, no new edge
    send_tick('0, 1'b0);
    send_tick(B_UP | B_LEFT | B_RIGHT, 1'b0);   // ignored outside edit
    send_tick(B_UP, 1'b1);                      // stale history: edge in edit
    send_tick('0, 1'b1);
    send_tick(B_DOWN, 1'b1);                    // back to zero
    send_tick(B_DOWN, 1'b1);
    send_tick('0, 1'b1);
    send_tick(B_DOWN, 1'b1);                    // clamp at zero
    send_tick('0, 1'b1);
    send_tick(B_RIGHT, 1'b1);                   // cursor wraps 0 -> 3
    send_tick('0, 1'b1);
    send_tick(B_LEFT, 1'b1);                    // cursor wraps 3 -> 0
    send_tick('0, 1'b1);
    send_tick(B_UP, 1'b1);                      // duty 1000, at the period
    send_tick('0, 1'b1);
    send_tick(B_ALL, 1'b1);                     // moves cancel, up then down
    send_tick('0, 1'b1);
    send_tick(B_UP | B_RIGHT, 1'b1);            // move then edit digit 3
    send_tick('0, 1'b0);
    send_tick(B_DOWN, 1'b1);                    // down edge in edit: no pulse
    send_tick(B_DOWN, 1'b0);
    send_tick(B_ALL, 1'b0);
  endtask

  // Press/release pairs in edit mode, leaning on one button per session
  task automatic edit_session();
    int               pairs;
    int               pick;
    int               favor;
    logic [BTN_W-1:0] press;
    pairs = $urandom_range(2, 16);
    favor = ($urandom_range(0, 2) != 0) ? $urandom_range(BTN_UP, BTN_DOWN)
                                        : $urandom_range(BTN_LEFT, BTN_RIGHT);
    repeat (pairs) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) press = BTN_W'(1) << favor;
      else if (pick < 9) press = BTN_W'(1) << $urandom_range(0, BTN_W - 1);
      else press = BTN_W'($urandom_range(1, 15));
      send_tick(press, 1'b1);
      repeat ($urandom_range(0, 2)) send_tick(press, 1'b1);
      send_tick(($urandom_range(0, 3) == 0) ? (press & BTN_W'($urandom())) : '0, 1'b1);
    end
  endtask

  // Down presses outside edit with the other buttons random
  task automatic pulse_session();
    repeat ($urandom_range(2, 10)) begin
      send_tick(B_DOWN | BTN_W'($urandom()), 1'b0);
      send_tick(~B_DOWN & BTN_W'($urandom()), 1'b0);
    end
  endtask

  task automatic random_ticks(input int count);
    int target;
    int pick;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        edit_session();
      end else if (pick < 17) begin
        pulse_session();
      end else begin
        repeat ($urandom_range(1, 12))
          send_tick(BTN_W'($urandom()), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    cfg_t c;
    int   phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    random_ticks(PHASE_TICKS);

    // fields: pwm_period, blink_period, blank_from
    phase = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      case (phase)
        0: c = {10'd1023, 10'd1023, 10'd0};
        1: c = {10'd1, 10'd1, 10'd1023};
        2: c = {10'd5, 10'd1, 10'd0};
        default: begin
          c.pwm_period = pick_period();
          c.blink_period = pick_period();
          case ($urandom_range(0, 3))
            0:       c.blank_from = '0;
            1:       c.blank_from = CNT_W'(1023);
            default: c.blank_from = CNT_W'($urandom_range(0, c.blink_period));
          endcase
        end
      endcase
      apply_config(c);
      random_ticks(PHASE_TICKS);
      phase++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sbp_pkg.sv
sv/sbp_regs.sv
sv/sbp_core.sv
sv/bcd_setpoint_panel_pwm_top.sv
sim/panel_checker.sv
sim/testbench.sv
